@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge of clk_i outside reset.
`define DAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition at one edge is followed by another at the next edge.
`define DAR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/dar_pkg.sv @@
// Types, constants and reply tables of the DNS A-record responder.
`timescale 1ns / 1ps
package dar_pkg;

  localparam int MaxNameDefault = 255;
  localparam int QueueDepthDefault = 4;
  localparam int PosW = 9;
  localparam int AnsIdxW = 5;
  localparam logic [AnsIdxW-1:0] AnsLastIdx = 5'd20;
  localparam logic [PosW-1:0] HdrLastPos = 9'd11;

  typedef enum logic {
    KIND_BYTE,
    KIND_ANSWER
  } dar_kind_e;

  typedef struct packed {
    dar_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic       err;
  } dar_cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0: b = 8'h81;
      4'd1: b = 8'h80;
      4'd3: b = 8'h01;
      4'd5: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ans_byte(input logic [AnsIdxW-1:0] idx,
                                          input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      5'd2, 5'd4, 5'd8, 5'd10: b = 8'h01;
      5'd5: b = 8'hC0;
      5'd6: b = 8'h0C;
      5'd14: b = 8'h3C;
      5'd16: b = 8'h04;
      5'd17: b = addr[31:24];
      5'd18: b = addr[23:16];
      5'd19: b = addr[15:8];
      5'd20: b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/dar_front.sv @@
// Front end: accepts query words, tracks the query layout and issues reply commands.
`timescale 1ns / 1ps
module dar_front import dar_pkg::*; #(
  parameter int MAX_NAME = MaxNameDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output dar_cmd_t   q_cmd_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_DONE,
    PH_DISCARD
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            fire;
  logic            too_long;

  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && q_ready_i;
  assign too_long = ({1'b0, pos_q} + (PosW+1)'(1)) >= (PosW+1)'(MAX_NAME);

  always_comb begin
    phase_d = phase_q;
    pos_d = pos_q;
    q_push_o = 1'b0;
    q_cmd_o = '{kind: KIND_BYTE, data: 8'h00, last: 1'b0, err: 1'b0};
    if (fire) begin
      case (phase_q)
        PH_HEADER: begin
          q_push_o = 1'b1;
          if (in_last_i) begin
            q_cmd_o.last = 1'b1;
            q_cmd_o.err = 1'b1;
            pos_d = '0;
          end else begin
            q_cmd_o.data = (pos_q < PosW'(2)) ? in_byte_i : hdr_byte(pos_q[3:0] - 4'd2);
            if (pos_q >= HdrLastPos) begin
              pos_d = '0;
              phase_d = PH_NAME;
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end
        end
        PH_NAME: begin
          q_push_o = 1'b1;
          if (in_byte_i == 8'h00) begin
            q_cmd_o.kind = KIND_ANSWER;
            pos_d = '0;
            phase_d = in_last_i ? PH_HEADER : PH_DONE;
          end else if (in_last_i || too_long) begin
            q_cmd_o.last = 1'b1;
            q_cmd_o.err = 1'b1;
            pos_d = '0;
            phase_d = in_last_i ? PH_HEADER : PH_DISCARD;
          end else begin
            q_cmd_o.data = in_byte_i;
            pos_d = pos_q + PosW'(1);
          end
        end
        default: begin
          if (in_last_i) begin
            pos_d = '0;
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/core/dar_queue.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module dar_queue import dar_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dar_cmd_t push_cmd_i,
  output logic     ready_o,
  input  logic     pop_i,
  output dar_cmd_t head_o,
  output logic     empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dar_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = count_q != CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/core/dar_back.sv @@
// Back end: turns reply commands into output words, expanding the answer record.
`timescale 1ns / 1ps
module dar_back import dar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dar_cmd_t    head_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [31:0] addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_err_o
);

  typedef enum logic {
    ST_PASS,
    ST_BURST
  } state_e;

  state_e             state_q;
  logic [AnsIdxW-1:0] idx_q;
  logic               valid_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               err_q;
  logic               out_free;

  assign out_free = !valid_q || out_ready_i;
  assign pop_o = (state_q == ST_PASS) && !empty_i && out_free;

  assign out_valid_o = valid_q;
  assign out_byte_o = byte_q;
  assign out_last_o = last_q;
  assign out_err_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PASS;
      idx_q <= '0;
      valid_q <= 1'b0;
      byte_q <= 8'h00;
      last_q <= 1'b0;
      err_q <= 1'b0;
    end else if (out_free) begin
      case (state_q)
        ST_PASS: begin
          valid_q <= !empty_i;
          if (!empty_i) begin
            if (head_i.kind == KIND_ANSWER) begin
              byte_q <= 8'h00;
              last_q <= 1'b0;
              err_q <= 1'b0;
              idx_q <= AnsIdxW'(1);
              state_q <= ST_BURST;
            end else begin
              byte_q <= head_i.data;
              last_q <= head_i.last;
              err_q <= head_i.err;
            end
          end
        end
        ST_BURST: begin
          valid_q <= 1'b1;
          byte_q <= ans_byte(idx_q, addr_i);
          last_q <= idx_q == AnsLastIdx;
          err_q <= 1'b0;
          idx_q <= idx_q + AnsIdxW'(1);
          if (idx_q == AnsLastIdx) begin
            state_q <= ST_PASS;
          end
        end
        default: begin
          state_q <= ST_PASS;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/dns_a_record_responder.sv @@
// Top level of the DNS A-record responder with its register port.
// Query words enter one per cycle and each header or name word yields one reply word
// through a four-entry command queue. The name terminator yields a burst of 21 words
// that the back end sends one per cycle while the output is ready, so input is taken at
// one word per cycle until the command queue fills behind such a burst; the back end's
// output register sets the sustained rate of one reply word per cycle while the output
// is ready. Register answer_address sits at byte address 0 and resets to zero.
`timescale 1ns / 1ps
module dns_a_record_responder import dar_pkg::*; #(
  parameter int MAX_NAME = MaxNameDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] query_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] reply_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] reply_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] answer_address_q;
  logic        q_ready, q_push, q_pop, q_empty;
  dar_cmd_t    q_cmd, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? answer_address_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_address_q <= 32'h0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      answer_address_q <= pwdata;
    end
  end

  dar_front #(.MAX_NAME(MAX_NAME)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  dar_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  dar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .addr_i      (answer_address_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

@@ rtl/core/dar_checker.sv @@
// Port-level checker of the DNS A-record responder and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic       out_stall;
  logic       err_beat;
  logic       err_ok;
  logic [9:0] out_word;
  logic       cfg_write;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign err_beat = m_axis_tvalid && m_axis_tuser;
  assign err_ok = m_axis_tlast && (m_axis_tdata == 8'h00);
  assign out_word = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

  // An error word is always a zero byte that closes the reply.
  `DAR_ASSERT(a_err_word, !err_beat || err_ok, "error word malformed")
  `DAR_ASSERT_NEXT(a_out_hold_valid, out_stall, m_axis_tvalid, "output word dropped")
  `DAR_ASSERT_NEXT(a_out_hold_data, out_stall, $stable(out_word), "stalled word changed")
  // A completed register write reads back on the next cycle.
  `DAR_ASSERT_NEXT(a_cfg_readback, cfg_write, paddr[2] || (prdata == $past(pwdata)), "write lost")

endmodule

bind dns_a_record_responder dar_checker u_dar_checker (.*);

@@ bench/dns_a_record_responder_test.sv @@
// Self-checking testbench that streams DNS queries into the responder and checks every reply word.
`timescale 1ns / 1ps
module dns_a_record_responder_test;
  import dar_pkg::*;

  localparam int NAME_LIMIT = MaxNameDefault;
  localparam int DRAIN_CYCLES = 40;
  localparam int SINK_HOLD_CYCLES = 200;
  localparam longint RUN_LIMIT_NS = 10_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] ADDR_ANSWER = 3'd0;
  localparam logic [79:0] HEADER_FIXED = 80'h8180_0001_0001_0000_0000;
  localparam logic [127:0] ANSWER_FIXED = 128'h0001_0001_C00C_0001_0001_0000_003C_0004;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_DONE,
    PH_DISCARD
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } query_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } reply_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] query_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] reply_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;           // [0] reply_error
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  query_word_t  query_q[$];
  reply_word_t  reply_q[$];
  parse_phase_e parse_phase = PH_HEADER;
  logic [8:0]   parse_pos = 9'd0;
  logic [31:0]  answer_addr = 32'h0;
  int           fault_count = 0;
  int           stim_items = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           src_gap = 0;
  int           sink_gap = 0;
  bit           hold_go = 1'b0;
  logic         sink_hold = 1'b0;

  dns_a_record_responder #(
    .MAX_NAME(NAME_LIMIT)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic expect_reply(input logic [7:0] data, input logic last, input logic err);
    reply_word_t r;
    r.data = data;
    r.last = last;
    r.err = err;
    reply_q.push_back(r);
  endtask

  // Advances the parser by one accepted query word and records the reply words it owes.
  task automatic respond_to_byte(input logic [7:0] b, input logic last);
    case (parse_phase)
      PH_HEADER: begin
        if (last) begin
          parse_pos = 9'd0;
          expect_reply(8'h00, 1'b1, 1'b1);
        end else begin
          if (parse_pos < 9'd2) begin
            expect_reply(b, 1'b0, 1'b0);
          end else begin
            expect_reply(HEADER_FIXED[79 - 8 * (int'(parse_pos) - 2) -: 8], 1'b0, 1'b0);
          end
          if (parse_pos >= 9'd11) begin
            parse_pos = 9'd0;
            parse_phase = PH_NAME;
          end else begin
            parse_pos = parse_pos + 9'd1;
          end
        end
      end
      PH_NAME: begin
        if (b == 8'h00) begin
          expect_reply(8'h00, 1'b0, 1'b0);
          for (int k = 0; k < 16; k++) expect_reply(ANSWER_FIXED[127 - 8 * k -: 8], 1'b0, 1'b0);
          for (int k = 0; k < 4; k++) expect_reply(answer_addr[31 - 8 * k -: 8], k == 3, 1'b0);
          parse_pos = 9'd0;
          parse_phase = last ? PH_HEADER : PH_DONE;
        end else if (last || int'(parse_pos) + 1 >= NAME_LIMIT) begin
          expect_reply(8'h00, 1'b1, 1'b1);
          parse_pos = 9'd0;
          parse_phase = last ? PH_HEADER : PH_DISCARD;
        end else begin
          expect_reply(b, 1'b0, 1'b0);
          parse_pos = parse_pos + 9'd1;
        end
      end
      default: begin
        if (last) begin
          parse_pos = 9'd0;
          parse_phase = PH_HEADER;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin : query_driver
    query_word_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) respond_to_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (query_q.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else if (query_q.size() != 0) begin
          w = query_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= w.data;
          s_axis_tlast <= w.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : reply_monitor
    reply_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("%0t: reply word with none expected: data %02h last %0b err %0b",
                     $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          end
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last ||
              m_axis_tuser !== want.err) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("%0t: reply word expected data %02h last %0b err %0b, got %02h %0b %0b",
                       $realtime, want.data, want.last, want.err,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
          end
        end
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Holds the reply side off for a long stretch so that the block backs up into its input.
  initial begin : sink_hold_proc
    wait (hold_go);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("dns_a_record_responder verification failed");
    $finish;
  end

  task automatic queue_word(input logic [7:0] data, input logic last);
    query_word_t w;
    w.data = data;
    w.last = last;
    query_q.push_back(w);
    stim_items++;
  endtask

  // Header bytes, non-zero name bytes, an optional terminator and trailing bytes;
  // the final word of the query carries the last flag.
  task automatic queue_query(input int hdr_len, input int name_len, input bit with_term,
                             input int tail_len);
    int n;
    logic [7:0] b;
    n = hdr_len + name_len + int'(with_term) + tail_len;
    for (int i = 0; i < n; i++) begin
      if (i < hdr_len) begin
        b = 8'($urandom_range(0, 255));
      end else if (i < hdr_len + name_len) begin
        b = 8'($urandom_range(1, 255));
      end else if (with_term && i == hdr_len + name_len) begin
        b = 8'h00;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      queue_word(b, i == n - 1);
    end
  endtask

  task automatic queue_random_query();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      queue_query(12, $urandom_range(0, 20), 1'b1,
                  ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 3));
    end else if (pick < 80) begin
      queue_query($urandom_range(1, 12), 0, 1'b0, 0);
    end else if (pick < 90) begin
      queue_query(12, $urandom_range(1, 6), 1'b0, 0);
    end else begin
      for (int i = $urandom_range(1, 6); i > 0; i--) begin
        queue_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic await_idle();
    while (query_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_answer_addr(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ANSWER;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    answer_addr = value;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_answer_addr(32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) queue_word((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b1);
    queue_word(8'hA5, 1'b1);
    queue_query(12, 1, 1'b0, 0);
    queue_query(12, 2, 1'b1, 2);
    await_idle();

    // A name that runs past the limit mid-query, followed by trailing words.
    write_answer_addr(32'h0000_0000);
    queue_query(12, NAME_LIMIT, 1'b0, 3);
    await_idle();

    write_answer_addr($urandom());
    src_idle_pct = 20;
    sink_idle_pct = 20;
    stim_items = 0;
    while (stim_items < 70) queue_random_query();
    hold_go = 1'b1;
    await_idle();

    write_answer_addr($urandom());
    src_idle_pct = 0;
    sink_idle_pct = 0;
    stim_items = 0;
    while (stim_items < 30) queue_random_query();
    await_idle();

    if (fault_count == 0) begin
      $display("dns_a_record_responder verification clean");
    end else begin
      $display("dns_a_record_responder verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/dar_pkg.sv
rtl/core/dar_front.sv
rtl/core/dar_queue.sv
rtl/core/dar_back.sv
rtl/core/dns_a_record_responder.sv
rtl/core/dar_checker.sv
bench/dns_a_record_responder_test.sv
